// ===== rtl/lzw_variable_width_decoder_defines.svh =====
// Assertion macros shared by the checker of the LZW decoder.
// Depends on nothing; include once per file that asserts.
`ifndef LZW_VARIABLE_WIDTH_DECODER_DEFINES_SVH
`define LZW_VARIABLE_WIDTH_DECODER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define LVWD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lzw decoder check failed");

// Next-cycle implication, disabled in reset
`define LVWD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lzw decoder check failed");

`endif

// ===== rtl/lvwd_pkg.sv =====
// Shared types and constants of the LZW decoder.
// Used by lvwd_ctrl, lvwd_dp and the top level; depends on nothing.
package lvwd_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int CHUNK_BYTES_DEF   = 64;

    localparam logic [12:0] CLEAR_CODE = 13'd256;
    localparam logic [12:0] END_CODE   = 13'd257;
    localparam logic [3:0]  MIN_WIDTH  = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CODE,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_FIX,
        ST_OUT_RD,
        ST_OUT_WR,
        ST_SEND,
        ST_FLAG
    } state_t;

    typedef enum logic [2:0] {
        KIND_CLEAR,
        KIND_END,
        KIND_FIRST,
        KIND_BAD,
        KIND_NORM,
        KIND_KWK
    } code_kind_t;

    typedef struct packed {
        logic accept;
        logic decode;
        logic walk_lit;
        logic walk_wr;
        logic fix;
        logic out_wr;
        logic send_next;
    } dp_cmd_t;

    typedef struct packed {
        logic       live;
        logic       fin;
        code_kind_t kind;
        logic       cur_lit;
        logic       walk_limit;
        logic       out_last;
        logic       chunk_full;
        logic       last;
    } dp_status_t;

endpackage

// ===== rtl/lzw_variable_width_decoder.sv =====
// Top level of the variable-width LZW decoder (9 to 12 bit codes, MSB first).
// Depends on lvwd_pkg, lvwd_ctrl and lvwd_dp.
//
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_data_byte, s_finish
// m_       out        m_valid / m_ready   m_word0..7, m_byte_count, flags
// cfg_     in         cfg_wr_en           cfg_wr_data (early change)
//
// One word at a time: each word is accepted (IDLE) and decoded (CODE). A code
// that is walked takes a read and a write state per chained string byte, a read
// for the final literal and a fix-up state; a first code after a clear skips the
// walk and the fix-up. Unloading the stack takes a read and a write state per
// byte, and each chunk then waits in the output register; a low m_ready holds it there.
// Reset is synchronous on aresetn; the memories need no clearing pass.
module lzw_variable_width_decoder #(
    parameter int TABLE_ENTRIES = lvwd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = lvwd_pkg::MAX_CODE_BITS_DEF,
    parameter int CHUNK_BYTES   = lvwd_pkg::CHUNK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_finish,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_word0,
    output logic [63:0] m_word1,
    output logic [63:0] m_word2,
    output logic [63:0] m_word3,
    output logic [63:0] m_word4,
    output logic [63:0] m_word5,
    output logic [63:0] m_word6,
    output logic [63:0] m_word7,
    output logic [6:0]  m_byte_count,
    output logic        m_last_chunk,
    output logic        m_end_of_data,
    output logic        m_code_error
);

    lvwd_pkg::dp_cmd_t    cmd;
    lvwd_pkg::dp_status_t status;
    logic [511:0]         chunk;

    lvwd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .status  (status),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    lvwd_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .CHUNK_BYTES   (CHUNK_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data_byte (s_data_byte),
        .s_finish    (s_finish),
        .cmd         (cmd),
        .status      (status),
        .chunk       (chunk),
        .byte_count  (m_byte_count),
        .last        (m_last_chunk),
        .eod         (m_end_of_data),
        .err         (m_code_error)
    );

    // Split the chunk into words, earliest byte on top
    assign m_word0 = chunk[511:448];
    assign m_word1 = chunk[447:384];
    assign m_word2 = chunk[383:320];
    assign m_word3 = chunk[319:256];
    assign m_word4 = chunk[255:192];
    assign m_word5 = chunk[191:128];
    assign m_word6 = chunk[127:64];
    assign m_word7 = chunk[63:0];

endmodule

// ===== rtl/lvwd_ctrl.sv =====
// Controller state machine of the LZW decoder.
// Depends on lvwd_pkg; drives commands into lvwd_dp from its status.
module lvwd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  m_ready,
    input  lvwd_pkg::dp_status_t  status,
    output logic                  s_ready,
    output logic                  m_valid,
    output lvwd_pkg::dp_cmd_t     cmd
);

    lvwd_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lvwd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lvwd_pkg::ST_IDLE: begin
                if (s_valid) state_next = lvwd_pkg::ST_CODE;
            end
            lvwd_pkg::ST_CODE: begin
                if (!status.live) begin
                    state_next = status.fin ? lvwd_pkg::ST_FLAG : lvwd_pkg::ST_IDLE;
                end else begin
                    case (status.kind)
                        lvwd_pkg::KIND_CLEAR:
                            state_next = status.fin ? lvwd_pkg::ST_FLAG : lvwd_pkg::ST_IDLE;
                        lvwd_pkg::KIND_END:   state_next = lvwd_pkg::ST_FLAG;
                        lvwd_pkg::KIND_BAD:   state_next = lvwd_pkg::ST_FLAG;
                        lvwd_pkg::KIND_FIRST: state_next = lvwd_pkg::ST_OUT_RD;
                        default:              state_next = lvwd_pkg::ST_WALK_RD;
                    endcase
                end
            end
            lvwd_pkg::ST_WALK_RD: begin
                if (status.cur_lit || status.walk_limit) state_next = lvwd_pkg::ST_FIX;
                else state_next = lvwd_pkg::ST_WALK_WR;
            end
            lvwd_pkg::ST_WALK_WR: state_next = lvwd_pkg::ST_WALK_RD;
            lvwd_pkg::ST_FIX:     state_next = lvwd_pkg::ST_OUT_RD;
            lvwd_pkg::ST_OUT_RD:  state_next = lvwd_pkg::ST_OUT_WR;
            lvwd_pkg::ST_OUT_WR: begin
                if (status.out_last || status.chunk_full) state_next = lvwd_pkg::ST_SEND;
                else state_next = lvwd_pkg::ST_OUT_RD;
            end
            lvwd_pkg::ST_SEND: begin
                if (m_ready) begin
                    state_next = status.last ? lvwd_pkg::ST_IDLE : lvwd_pkg::ST_OUT_RD;
                end
            end
            lvwd_pkg::ST_FLAG: begin
                if (m_ready) state_next = lvwd_pkg::ST_IDLE;
            end
            default: state_next = lvwd_pkg::ST_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = '0;
        case (state_reg)
            lvwd_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            lvwd_pkg::ST_CODE:    cmd.decode   = 1'b1;
            lvwd_pkg::ST_WALK_RD: cmd.walk_lit = status.cur_lit;
            lvwd_pkg::ST_WALK_WR: cmd.walk_wr  = 1'b1;
            lvwd_pkg::ST_FIX:     cmd.fix      = 1'b1;
            lvwd_pkg::ST_OUT_WR:  cmd.out_wr   = 1'b1;
            lvwd_pkg::ST_SEND: begin
                m_valid       = 1'b1;
                cmd.send_next = m_ready && !status.last;
            end
            lvwd_pkg::ST_FLAG: m_valid = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== rtl/lvwd_dp.sv =====
// Datapath of the LZW decoder: bit buffer, dictionary, string stack, chunk.
// Depends on lvwd_pkg; steered by commands from lvwd_ctrl.
module lvwd_dp #(
    parameter int TABLE_ENTRIES = lvwd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = lvwd_pkg::MAX_CODE_BITS_DEF,
    parameter int CHUNK_BYTES   = lvwd_pkg::CHUNK_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_finish,
    input  lvwd_pkg::dp_cmd_t     cmd,
    output lvwd_pkg::dp_status_t  status,
    output logic [511:0]          chunk,
    output logic [6:0]            byte_count,
    output logic                  last,
    output logic                  eod,
    output logic                  err
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int NW = AW + 1;
    localparam int CB = MAX_CODE_BITS;
    localparam int PW = $clog2(CHUNK_BYTES + 1);

    logic [19:0]   buf_reg;
    logic [4:0]    held_reg;
    logic [3:0]    width_reg;
    logic [AW-1:0] newest_reg;
    logic [AW-1:0] prev_reg;
    logic          prev_valid_reg;
    logic          ended_reg;
    logic          ec_reg;
    logic [CB-1:0] code_reg;
    logic          have_reg;
    logic          fin_reg;
    logic [AW-1:0] cur_reg;
    logic [NW-1:0] n_reg;
    logic [7:0]    fb_reg;
    logic          kwk_reg;
    logic          eod_reg;
    logic          err_reg;
    logic          last_reg;
    logic [PW-1:0] pos_reg;
    logic [511:0]  chunk_reg;
    logic [511:0]  chunk_next;

    logic [AW-1:0] prefix_mem [TABLE_ENTRIES];
    logic [7:0]    suffix_mem [TABLE_ENTRIES];
    logic [7:0]    stack_mem  [TABLE_ENTRIES];
    logic [AW-1:0] pq;
    logic [7:0]    sq;
    logic [7:0]    stq;

    // Code extraction from the shifted buffer
    logic [19:0] buf_new;
    logic [4:0]  held_sum;
    logic [4:0]  held_new;
    logic [19:0] mask20;
    logic [19:0] code_full;
    logic        have_new;

    assign buf_new   = {buf_reg[11:0], s_data_byte};
    assign held_sum  = held_reg + 5'd8;
    assign have_new  = held_sum >= {1'b0, width_reg};
    assign held_new  = held_sum - {1'b0, width_reg};
    assign mask20    = (20'd1 << width_reg) - 20'd1;
    assign code_full = (buf_new >> held_new) & mask20;

    // Classify the held code
    logic [12:0]           code13;
    logic [12:0]           nw1;
    lvwd_pkg::code_kind_t  kind;

    assign code13 = 13'(code_reg);
    assign nw1    = 13'(newest_reg) + 13'd1;

    always_comb begin
        if (code13 == lvwd_pkg::CLEAR_CODE) begin
            kind = lvwd_pkg::KIND_CLEAR;
        end else if (code13 == lvwd_pkg::END_CODE) begin
            kind = lvwd_pkg::KIND_END;
        end else if (!prev_valid_reg) begin
            kind = (code13 < 13'd256) ? lvwd_pkg::KIND_FIRST : lvwd_pkg::KIND_BAD;
        end else if (code13 > nw1) begin
            kind = lvwd_pkg::KIND_BAD;
        end else if (code13 == nw1) begin
            kind = (nw1 >= 13'(TABLE_ENTRIES)) ? lvwd_pkg::KIND_BAD : lvwd_pkg::KIND_KWK;
        end else begin
            kind = lvwd_pkg::KIND_NORM;
        end
    end

    logic live;
    assign live = !ended_reg && have_reg;

    // Entry bookkeeping for the new dictionary entry
    logic          full;
    logic [AW-1:0] ne;
    logic [12:0]   wmask;
    logic [12:0]   wtarget;

    assign full    = newest_reg == AW'(TABLE_ENTRIES - 1);
    assign ne      = newest_reg + AW'(1);
    assign wmask   = (13'd1 << width_reg) - 13'd1;
    assign wtarget = wmask - 13'(ec_reg);

    // Status to the controller
    always_comb begin
        status.live       = live;
        status.fin        = fin_reg;
        status.kind       = kind;
        status.cur_lit    = cur_reg < AW'(256);
        status.walk_limit = n_reg == NW'(TABLE_ENTRIES - 1);
        status.out_last   = n_reg == NW'(1);
        status.chunk_full = pos_reg == PW'(CHUNK_BYTES - 1);
        status.last       = last_reg;
    end

    // Control and dictionary state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg        <= '0;
            held_reg       <= '0;
            width_reg      <= lvwd_pkg::MIN_WIDTH;
            newest_reg     <= AW'(lvwd_pkg::END_CODE);
            prev_valid_reg <= 1'b0;
            ended_reg      <= 1'b0;
            ec_reg         <= 1'b1;
            have_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) ec_reg <= cfg_wr_data;
            // Shift in the accepted word
            if (cmd.accept && !ended_reg) begin
                buf_reg  <= buf_new;
                held_reg <= have_new ? held_new : held_sum;
                have_reg <= have_new;
            end else if (cmd.accept) begin
                have_reg <= 1'b0;
            end
            if (cmd.decode) begin
                if (ended_reg && fin_reg) begin
                    buf_reg        <= '0;
                    held_reg       <= '0;
                    ended_reg      <= 1'b0;
                    width_reg      <= lvwd_pkg::MIN_WIDTH;
                    newest_reg     <= AW'(lvwd_pkg::END_CODE);
                    prev_valid_reg <= 1'b0;
                end else if (live) begin
                    case (kind)
                        lvwd_pkg::KIND_CLEAR: begin
                            width_reg      <= lvwd_pkg::MIN_WIDTH;
                            newest_reg     <= AW'(lvwd_pkg::END_CODE);
                            prev_valid_reg <= 1'b0;
                        end
                        lvwd_pkg::KIND_END: begin
                            if (fin_reg) begin
                                buf_reg        <= '0;
                                held_reg       <= '0;
                                width_reg      <= lvwd_pkg::MIN_WIDTH;
                                newest_reg     <= AW'(lvwd_pkg::END_CODE);
                                prev_valid_reg <= 1'b0;
                            end else begin
                                ended_reg <= 1'b1;
                            end
                        end
                        lvwd_pkg::KIND_FIRST: prev_valid_reg <= 1'b1;
                        default: ;
                    endcase
                end
            end
            // Add the entry and widen codes
            if (cmd.fix && !full) begin
                newest_reg <= ne;
                if (13'(ne) == wtarget && width_reg < 4'(CB)) begin
                    width_reg <= width_reg + 4'd1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            fin_reg <= s_finish;
            if (!ended_reg && have_new) code_reg <= code_full[CB-1:0];
        end
        if (cmd.decode) begin
            eod_reg   <= fin_reg || (live && kind == lvwd_pkg::KIND_END);
            err_reg   <= live && kind == lvwd_pkg::KIND_BAD;
            last_reg  <= 1'b1;
            pos_reg   <= '0;
            chunk_reg <= '0;
            kwk_reg   <= kind == lvwd_pkg::KIND_KWK;
            if (kind == lvwd_pkg::KIND_FIRST) begin
                n_reg    <= NW'(1);
                prev_reg <= AW'(code_reg);
            end else if (kind == lvwd_pkg::KIND_KWK) begin
                cur_reg <= prev_reg;
                n_reg   <= NW'(1);
            end else begin
                cur_reg <= AW'(code_reg);
                n_reg   <= '0;
            end
        end
        if (cmd.walk_lit) begin
            fb_reg <= cur_reg[7:0];
            n_reg  <= n_reg + NW'(1);
        end
        if (cmd.walk_wr) begin
            cur_reg <= pq;
            n_reg   <= n_reg + NW'(1);
        end
        if (cmd.fix) prev_reg <= AW'(code_reg);
        if (cmd.out_wr) begin
            chunk_reg <= chunk_next;
            pos_reg   <= pos_reg + PW'(1);
            n_reg     <= n_reg - NW'(1);
            last_reg  <= n_reg == NW'(1);
        end
        if (cmd.send_next) begin
            chunk_reg <= '0;
            pos_reg   <= '0;
        end
    end

    // Place the stack byte at the current chunk slot
    always_comb begin
        chunk_next = chunk_reg;
        for (int i = 0; i < CHUNK_BYTES; i++) begin
            if (pos_reg == PW'(i)) chunk_next[511 - 8 * i -: 8] = stq;
        end
    end

    // Dictionary memories
    always_ff @(posedge aclk) begin
        if (cmd.fix && !full) begin
            prefix_mem[ne] <= prev_reg;
            suffix_mem[ne] <= fb_reg;
        end
        pq <= prefix_mem[cur_reg];
        sq <= suffix_mem[cur_reg];
    end

    // String stack, last byte first
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [7:0]    st_wdata;
    logic [AW-1:0] st_raddr;

    always_comb begin
        st_we    = 1'b0;
        st_waddr = n_reg[AW-1:0];
        st_wdata = sq;
        if (cmd.decode && live && kind == lvwd_pkg::KIND_FIRST) begin
            st_we    = 1'b1;
            st_waddr = '0;
            st_wdata = code_reg[7:0];
        end else if (cmd.walk_lit) begin
            st_we    = 1'b1;
            st_wdata = cur_reg[7:0];
        end else if (cmd.walk_wr) begin
            st_we    = 1'b1;
        end else if (cmd.fix && kwk_reg) begin
            st_we    = 1'b1;
            st_waddr = '0;
            st_wdata = fb_reg;
        end
    end

    assign st_raddr = st_waddr - AW'(1);

    always_ff @(posedge aclk) begin
        if (st_we) stack_mem[st_waddr] <= st_wdata;
        stq <= stack_mem[st_raddr];
    end

    assign chunk      = chunk_reg;
    assign byte_count = 7'(pos_reg);
    assign last       = last_reg;
    assign eod        = last_reg && eod_reg;
    assign err        = last_reg && err_reg;

endmodule

// ===== rtl/lvwd_checker.sv =====
// Port-level checks of the LZW decoder, bound to the top level.
// Depends on lzw_variable_width_decoder_defines.svh.
`include "lzw_variable_width_decoder_defines.svh"

module lvwd_checker #(
    parameter int CHUNK_BYTES = 64
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_byte_count,
    input logic       m_last_chunk,
    input logic       m_end_of_data,
    input logic       m_code_error
);

    `LVWD_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `LVWD_ASSERT_NOW(a_no_overlap, aclk, aresetn, s_ready, !m_valid)
    `LVWD_ASSERT_NOW(a_full_chunk, aclk, aresetn, m_valid && !m_last_chunk, m_byte_count == 7'(CHUNK_BYTES))
    `LVWD_ASSERT_NOW(a_flags_last, aclk, aresetn, m_valid && (m_end_of_data || m_code_error || m_byte_count == 7'd0), m_last_chunk)

endmodule

bind lzw_variable_width_decoder lvwd_checker #(.CHUNK_BYTES(CHUNK_BYTES)) u_lvwd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_byte_count  (m_byte_count),
    .m_last_chunk  (m_last_chunk),
    .m_end_of_data (m_end_of_data),
    .m_code_error  (m_code_error)
);

// ===== tb/lzw_decode_checker.sv =====
// Checker for the LZW decoder: watches both channels and the config port,
// predicts every output word and compares it. Depends on lvwd_pkg.
`timescale 1ns / 100ps

module lzw_decode_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_finish,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_word0,
    input  logic [63:0] m_word1,
    input  logic [63:0] m_word2,
    input  logic [63:0] m_word3,
    input  logic [63:0] m_word4,
    input  logic [63:0] m_word5,
    input  logic [63:0] m_word6,
    input  logic [63:0] m_word7,
    input  logic [6:0]  m_byte_count,
    input  logic        m_last_chunk,
    input  logic        m_end_of_data,
    input  logic        m_code_error,
    output int          fail_count,
    output int          chunks_pending
);

    localparam int NUM_ENTRIES = lvwd_pkg::TABLE_ENTRIES_DEF;
    localparam int WIDEST      = lvwd_pkg::MAX_CODE_BITS_DEF;
    localparam int CHUNK_LEN   = lvwd_pkg::CHUNK_BYTES_DEF;
    localparam int FIRST_WIDTH = int'(lvwd_pkg::MIN_WIDTH);
    localparam int CLEAR       = int'(lvwd_pkg::CLEAR_CODE);
    localparam int FINISH_CODE = int'(lvwd_pkg::END_CODE);

    typedef struct packed {
        logic [7:0][63:0] words;
        logic [6:0]       byte_count;
        logic             last_chunk;
        logic             end_of_data;
        logic             code_error;
    } chunk_t;

    // decoder mirror
    logic [11:0] prefix_mem [NUM_ENTRIES];
    logic [7:0]  suffix_mem [NUM_ENTRIES];
    logic [19:0] shift_bits;
    int          bits_in;
    int          width;
    int          top_code;
    int          prior_code;
    bit          prior_ok;
    bit          stopped;
    bit          early;

    chunk_t      chunk_q [$];

    function automatic void restart_dict();
        width      = FIRST_WIDTH;
        top_code   = FINISH_CODE;
        prior_code = 0;
        prior_ok   = 0;
    endfunction

    function automatic logic [7:0] lead_byte(input int c);
        while (c >= 256) c = prefix_mem[c];
        return c[7:0];
    endfunction

    function automatic void grow_dict(input int pre, input logic [7:0] fb);
        if (top_code + 1 >= NUM_ENTRIES) return;
        top_code++;
        prefix_mem[top_code] = pre[11:0];
        suffix_mem[top_code] = fb;
        if (top_code == (1 << width) - 1 - int'(early) && width < WIDEST) width++;
    endfunction

    // Decode one input word and queue the chunks it produces
    function automatic void decode_word(input logic [7:0] b, input logic fin);
        logic [7:0] text [$];
        int         code;
        int         c;
        int         chunks;
        int         cnt;
        bit         err;
        bit         end_now;
        bit         eod;
        chunk_t     ch;
        err     = 0;
        end_now = 0;
        if (!stopped) begin
            shift_bits = {shift_bits[11:0], b};
            bits_in += 8;
            if (bits_in >= width) begin
                bits_in -= width;
                code = int'((shift_bits >> bits_in) & ((20'd1 << width) - 20'd1));
                if (code == CLEAR) begin
                    restart_dict();
                end else if (code == FINISH_CODE) begin
                    stopped = 1;
                    end_now = 1;
                end else if (!prior_ok) begin
                    if (code < 256) begin
                        text.push_back(code[7:0]);
                        prior_code = code;
                        prior_ok   = 1;
                    end else begin
                        err = 1;
                    end
                end else if (code > top_code + 1 ||
                             (code == top_code + 1 && top_code + 1 >= NUM_ENTRIES)) begin
                    err = 1;
                end else begin
                    grow_dict(prior_code, (code == top_code + 1) ? lead_byte(prior_code)
                                                                 : lead_byte(code));
                    // walk the chain, earliest byte ends up first
                    c = code;
                    while (c >= 256) begin
                        text.push_front(suffix_mem[c]);
                        c = prefix_mem[c];
                    end
                    text.push_front(c[7:0]);
                    prior_code = code;
                end
            end
        end
        eod = end_now || fin;
        if (fin && stopped) begin
            shift_bits = '0;
            bits_in    = 0;
            stopped    = 0;
            restart_dict();
        end
        chunks = (text.size() + CHUNK_LEN - 1) / CHUNK_LEN;
        if (chunks == 0 && (eod || err)) chunks = 1;
        if (chunks > 64) chunks = 64;
        for (int k = 0; k < chunks; k++) begin
            ch  = '0;
            cnt = text.size() - k * CHUNK_LEN;
            if (cnt < 0) cnt = 0;
            if (cnt > CHUNK_LEN) cnt = CHUNK_LEN;
            // word0 sits in the top slice of the packed words
            for (int p = 0; p < cnt; p++)
                ch.words[7 - p / 8][63 - 8 * (p % 8) -: 8] = text[k * CHUNK_LEN + p];
            ch.byte_count  = cnt[6:0];
            ch.last_chunk  = (k + 1 == chunks);
            ch.end_of_data = (k + 1 == chunks) && eod;
            ch.code_error  = (k + 1 == chunks) && err;
            chunk_q.push_back(ch);
        end
    endfunction

    // Report a mismatch; only the first ten get printed
    function automatic void flag_mismatch(input string what, input chunk_t want,
                                          input chunk_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch at %0t: %s\n  want %h\n  got  %h", $realtime, what,
                     want, got);
    endfunction

    always @(posedge aclk) begin
        chunk_t seen;
        chunk_t want;
        if (!aresetn) begin
            shift_bits = '0;
            bits_in    = 0;
            stopped    = 0;
            early      = 1;
            fail_count = 0;
            restart_dict();
            chunk_q.delete();
        end else begin
            if (cfg_wr_en) early = cfg_wr_data;
            if (s_valid && s_ready) decode_word(s_data_byte, s_finish);
            if (m_valid && m_ready) begin
                seen.words       = {m_word0, m_word1, m_word2, m_word3,
                                    m_word4, m_word5, m_word6, m_word7};
                seen.byte_count  = m_byte_count;
                seen.last_chunk  = m_last_chunk;
                seen.end_of_data = m_end_of_data;
                seen.code_error  = m_code_error;
                if (chunk_q.size() == 0) begin
                    flag_mismatch("unexpected word", '0, seen);
                end else begin
                    want = chunk_q.pop_front();
                    if (seen.words != want.words) flag_mismatch("data words", want, seen);
                    else if (seen.byte_count != want.byte_count)
                        flag_mismatch("byte_count", want, seen);
                    else if (seen.last_chunk != want.last_chunk)
                        flag_mismatch("last_chunk", want, seen);
                    else if (seen.end_of_data != want.end_of_data)
                        flag_mismatch("end_of_data", want, seen);
                    else if (seen.code_error != want.code_error)
                        flag_mismatch("code_error", want, seen);
                end
            end
        end
        chunks_pending = chunk_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the LZW decoder testbench: clock, reset, encoded byte streams,
// receiver stalls and the verdict. Depends on lvwd_pkg and lzw_decode_checker.
`timescale 1ns / 100ps

module testbench;

    localparam int LIMIT       = 1000000;
    localparam int NUM_ENTRIES = lvwd_pkg::TABLE_ENTRIES_DEF;
    localparam int WIDEST      = lvwd_pkg::MAX_CODE_BITS_DEF;
    localparam int FIRST_WIDTH = int'(lvwd_pkg::MIN_WIDTH);
    localparam int CLEAR       = int'(lvwd_pkg::CLEAR_CODE);
    localparam int FINISH_CODE = int'(lvwd_pkg::END_CODE);
    localparam int RANDOM_WORDS = 210;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       finish;
    } in_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        s_finish = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_word0, m_word1, m_word2, m_word3;
    logic [63:0] m_word4, m_word5, m_word6, m_word7;
    logic [6:0]  m_byte_count;
    logic        m_last_chunk;
    logic        m_end_of_data;
    logic        m_code_error;
    int          fail_count;
    int          chunks_pending;

    // encoder side: mirrors code width and table fill to pack legal codes
    in_word_t    word_q [$];
    logic [31:0] pack_bits;
    int          pack_n;
    int          enc_width;
    int          enc_top;
    bit          enc_prior;
    bit          enc_early;
    int          sent_words;
    int          cycles = 0;

    always #5 aclk = ~aclk;

    lzw_variable_width_decoder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_finish(s_finish),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_word0(m_word0), .m_word1(m_word1), .m_word2(m_word2), .m_word3(m_word3),
        .m_word4(m_word4), .m_word5(m_word5), .m_word6(m_word6), .m_word7(m_word7),
        .m_byte_count(m_byte_count), .m_last_chunk(m_last_chunk),
        .m_end_of_data(m_end_of_data), .m_code_error(m_code_error)
    );

    lzw_decode_checker checker_i (.*);

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Receiver: shifting stall patterns plus one long hold-off mid-stream
    int long_hold = 0;
    bit held_once = 0;
    int rx_mode = 0;
    int rx_left = 0;
    always @(posedge aclk) begin
        if (!held_once && sent_words >= 60) begin
            long_hold = 600;
            held_once = 1;
        end
        if (long_hold > 0) begin
            long_hold--;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(16, 80);
            end
            rx_left--;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic void restart_encoder();
        enc_width = FIRST_WIDTH;
        enc_top   = FINISH_CODE;
        enc_prior = 0;
    endfunction

    // Pack one code MSB first and track what the decoder will do with it
    function automatic void put_code(input int code, input bit fin_ok = 1,
                                     input bit fin_force = 0);
        in_word_t w;
        pack_bits = (pack_bits << enc_width) | code;
        pack_n += enc_width;
        while (pack_n >= 8) begin
            pack_n -= 8;
            w.data_byte = pack_bits[pack_n +: 8];
            w.finish    = fin_force || (fin_ok && $urandom_range(0, 24) == 0);
            fin_force   = 0;
            word_q.push_back(w);
        end
        if (code == CLEAR) begin
            restart_encoder();
        end else if (!enc_prior) begin
            if (code < 256) enc_prior = 1;
        end else if (code <= enc_top + 1 && enc_top + 1 < NUM_ENTRIES) begin
            enc_top++;
            if (enc_top == (1 << enc_width) - 1 - int'(enc_early) && enc_width < WIDEST)
                enc_width++;
        end
    endfunction

    // End code, pad, some ignored bytes, then the finish word
    function automatic void end_stream();
        in_word_t w;
        put_code(FINISH_CODE, 0);
        if (pack_n > 0) begin
            w.data_byte = 8'(pack_bits << (8 - pack_n));
            w.finish    = 0;
            word_q.push_back(w);
        end
        repeat ($urandom_range(0, 2)) begin
            w.data_byte = 8'($urandom);
            w.finish    = 0;
            word_q.push_back(w);
        end
        w.data_byte = 8'($urandom);
        w.finish    = 1;
        word_q.push_back(w);
        pack_bits = '0;
        pack_n    = 0;
        restart_encoder();
    endfunction

    // Choose a random code that mostly keeps the stream legal
    function automatic int pick_code();
        int roll;
        int span_top;
        roll     = $urandom_range(0, 99);
        span_top = (1 << enc_width) - 1;
        if (!enc_prior) begin
            if (roll < 4) return CLEAR;
            if (roll < 8) return $urandom_range(FINISH_CODE + 1, span_top);
            return $urandom_range(0, 255);
        end
        if (roll < 3) return CLEAR;
        if (roll < 6 && enc_top + 2 <= span_top) return $urandom_range(enc_top + 2, span_top);
        if (roll < 16 && enc_top + 1 < NUM_ENTRIES) return enc_top + 1;
        if (roll < 45 && enc_top > FINISH_CODE) return $urandom_range(FINISH_CODE + 1, enc_top);
        return $urandom_range(0, 255);
    endfunction

    // Send queued words in bursts with random gaps
    task automatic drain_words();
        int burst;
        in_word_t w;
        burst = $urandom_range(1, 20);
        while (word_q.size() > 0) begin
            w = word_q.pop_front();
            s_valid     <= 1'b1;
            s_data_byte <= w.data_byte;
            s_finish    <= w.finish;
            @(negedge aclk);
            while (!s_ready) @(negedge aclk);
            @(posedge aclk);
            sent_words++;
            burst--;
            if (burst == 0 && word_q.size() > 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold the sender until every chunk is back, then let the block settle
    task automatic wait_idle();
        @(negedge aclk);
        while (chunks_pending != 0) @(negedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_early(input bit val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        enc_early = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        pack_bits  = '0;
        pack_n     = 0;
        enc_early  = 1;
        sent_words = 0;
        restart_encoder();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: literal extremes, string growth, self-reference, clear,
        // bad first code, code past the table, finish mid-stream, end code
        put_code(CLEAR, 0);
        put_code(300, 0);
        put_code(0, 0);
        put_code(255, 0);
        put_code(enc_top + 1, 0);
        put_code(258, 0, 1);
        put_code(enc_top + 5, 0);
        put_code(259, 0);
        put_code(CLEAR, 0);
        put_code(170, 0);
        put_code(85, 0);
        end_stream();
        drain_words();
        wait_idle();

        // random streams with early change off, some long self-reference runs
        write_early(0);
        while (sent_words < RANDOM_WORDS - 45) begin
            put_code($urandom_range(0, 255));
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(20, 75)) put_code(enc_top + 1, 0);
            end
            repeat ($urandom_range(5, 40)) put_code(pick_code());
            end_stream();
            drain_words();
        end
        wait_idle();

        // short random stream with early change on again
        write_early(1);
        put_code($urandom_range(0, 255));
        repeat (30) put_code(pick_code());
        end_stream();
        drain_words();

        @(negedge aclk);
        while (chunks_pending != 0) @(negedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
